// ----- hdl/mbrc_pkg.sv -----
`default_nettype none
package mbrc_pkg;

	localparam int unsigned DATA_W = 8;
	localparam int unsigned LEN_W  = 9;
	localparam int unsigned CRC_W  = 16;

	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

	// configuration register indexes
	localparam int unsigned REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_EXP_ADDR = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_EXP_FUNC = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MIN_LEN  = 2'd2;

	localparam logic [DATA_W-1:0] EXP_ADDR_RST = 8'd1;
	localparam logic [DATA_W-1:0] EXP_FUNC_RST = 8'd3;
	localparam logic [LEN_W-1:0]  MIN_LEN_RST  = 9'd71;

	// frame status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FAIL  = 2'd1;
	localparam logic [1:0] STATUS_SHORT = 2'd2;

	// frame byte positions (data offset + 3)
	localparam logic [LEN_W-1:0] POS_ADDR     = 9'd0;
	localparam logic [LEN_W-1:0] POS_FUNC     = 9'd1;
	localparam logic [LEN_W-1:0] POS_FLOW     = 9'd3;
	localparam logic [LEN_W-1:0] POS_FORWARD  = 9'd15;
	localparam logic [LEN_W-1:0] POS_REVERSE  = 9'd21;
	localparam logic [LEN_W-1:0] POS_PRESSURE = 9'd39;
	localparam logic [LEN_W-1:0] POS_MSTATUS  = 9'd41;
	localparam logic [LEN_W-1:0] POS_TEMP     = 9'd61;
	localparam logic [LEN_W-1:0] POS_SERIAL   = 9'd67;
	localparam logic [LEN_W-1:0] POS_ID       = 9'd72;
	localparam logic [LEN_W-1:0] POS_BAUD     = 9'd75;

	typedef struct packed {
		logic [31:0] flow;
		logic [31:0] forward_total;
		logic [31:0] reverse_total;
		logic [15:0] pressure;
		logic [15:0] meter_status;
		logic [15:0] temperature;
		logic [31:0] serial_number;
		logic [7:0]  device_id;
		logic [15:0] baud_setting;
	} meter_fields_t;

	// frame state as it stands after the current byte
	typedef struct packed {
		logic [LEN_W-1:0]  length;
		logic [CRC_W-1:0]  crc;
		logic [DATA_W-1:0] first_byte;
		logic [DATA_W-1:0] second_byte;
		meter_fields_t     fields;
	} frame_snap_t;

	function automatic logic [CRC_W-1:0] crc16_byte(
		input logic [CRC_W-1:0]  crc_in,
		input logic [DATA_W-1:0] b
	);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {{(CRC_W-DATA_W){1'b0}}, b};
		for (int k = 0; k < DATA_W; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/mbrc_frame_acc.sv -----
`default_nettype none
module mbrc_frame_acc
	import mbrc_pkg::*;
#(
	parameter int unsigned MAX_FRAME = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              beat_en,
	input  wire logic [DATA_W-1:0] data_byte,
	input  wire logic              frame_end,
	output frame_snap_t            snap
);

	localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);

	logic [CNT_W-1:0]  count_q;
	logic [CRC_W-1:0]  crc_q;
	logic [DATA_W-1:0] first_q;
	logic [DATA_W-1:0] second_q;
	meter_fields_t     fields_q;

	logic [CNT_W-1:0]  count_nx;
	logic [CRC_W-1:0]  crc_nx;
	logic [DATA_W-1:0] first_nx;
	logic [DATA_W-1:0] second_nx;
	meter_fields_t     fields_nx;
	logic [LEN_W-1:0]  pos;
	logic              counted;

	// 32-bit field sent low word first, each word big-endian
	function automatic logic [31:0] put_wordswap(
		input logic [31:0]       word,
		input logic [LEN_W-1:0]  p,
		input logic [LEN_W-1:0]  base,
		input logic [DATA_W-1:0] b
	);
		logic [31:0]      w;
		logic [LEN_W-1:0] off;
		w   = word;
		off = p - base;
		if (p >= base && off < 9'd4) begin
			case (off[1:0])
				2'd0:    w[15:8]  = b;
				2'd1:    w[7:0]   = b;
				2'd2:    w[31:24] = b;
				default: w[23:16] = b;
			endcase
		end
		return w;
	endfunction

	assign pos     = LEN_W'(count_q);
	assign counted = count_q < CNT_W'(MAX_FRAME);

	always_comb begin
		count_nx  = count_q;
		crc_nx    = crc_q;
		first_nx  = first_q;
		second_nx = second_q;
		fields_nx = fields_q;
		if (counted) begin
			count_nx = count_q + 1'b1;
			crc_nx   = crc16_byte(crc_q, data_byte);
			if (pos == POS_ADDR) first_nx = data_byte;
			if (pos == POS_FUNC) second_nx = data_byte;
			fields_nx.flow          = put_wordswap(fields_q.flow, pos, POS_FLOW, data_byte);
			fields_nx.forward_total = put_wordswap(fields_q.forward_total, pos, POS_FORWARD,
				data_byte);
			fields_nx.reverse_total = put_wordswap(fields_q.reverse_total, pos, POS_REVERSE,
				data_byte);
			if (pos == POS_PRESSURE)        fields_nx.pressure[15:8] = data_byte;
			if (pos == POS_PRESSURE + 9'd1) fields_nx.pressure[7:0]  = data_byte;
			if (pos == POS_MSTATUS)         fields_nx.meter_status[15:8] = data_byte;
			if (pos == POS_MSTATUS + 9'd1)  fields_nx.meter_status[7:0]  = data_byte;
			if (pos == POS_TEMP)            fields_nx.temperature[15:8] = data_byte;
			if (pos == POS_TEMP + 9'd1)     fields_nx.temperature[7:0]  = data_byte;
			if (pos == POS_SERIAL)          fields_nx.serial_number[31:24] = data_byte;
			if (pos == POS_SERIAL + 9'd1)   fields_nx.serial_number[23:16] = data_byte;
			if (pos == POS_SERIAL + 9'd2)   fields_nx.serial_number[15:8]  = data_byte;
			if (pos == POS_SERIAL + 9'd3)   fields_nx.serial_number[7:0]   = data_byte;
			if (pos == POS_ID)              fields_nx.device_id = data_byte;
			if (pos == POS_BAUD)            fields_nx.baud_setting[15:8] = data_byte;
			if (pos == POS_BAUD + 9'd1)     fields_nx.baud_setting[7:0]  = data_byte;
		end
	end

	always_comb begin
		snap.length      = LEN_W'(count_nx);
		snap.crc         = crc_nx;
		snap.first_byte  = first_nx;
		snap.second_byte = second_nx;
		snap.fields      = fields_nx;
	end

	// last beat of a frame leaves everything cleared for the next one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			crc_q    <= CRC_INIT;
			first_q  <= '0;
			second_q <= '0;
			fields_q <= '0;
		end else if (beat_en) begin
			if (frame_end) begin
				count_q  <= '0;
				crc_q    <= CRC_INIT;
				first_q  <= '0;
				second_q <= '0;
				fields_q <= '0;
			end else begin
				count_q  <= count_nx;
				crc_q    <= crc_nx;
				first_q  <= first_nx;
				second_q <= second_nx;
				fields_q <= fields_nx;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/mbrc_result_reg.sv -----
`default_nettype none
module mbrc_result_reg
	import mbrc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire frame_snap_t       snap,
	input  wire logic [DATA_W-1:0] exp_addr,
	input  wire logic [DATA_W-1:0] exp_func,
	input  wire logic [LEN_W-1:0]  min_len,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output logic [1:0]             status,
	output logic [LEN_W-1:0]       length,
	output meter_fields_t          fields
);

	logic              valid_q;
	logic [1:0]        status_q;
	logic [LEN_W-1:0]  length_q;
	meter_fields_t     fields_q;
	logic [1:0]        status_nx;

	always_comb begin
		if (snap.length < min_len) begin
			status_nx = STATUS_SHORT;
		end else if (snap.crc != '0 || snap.first_byte != exp_addr
				|| snap.second_byte != exp_func) begin
			status_nx = STATUS_FAIL;
		end else begin
			status_nx = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= status_nx;
			length_q <= snap.length;
			fields_q <= (status_nx == STATUS_OK) ? snap.fields : '0;
		end
	end

	assign out_valid = valid_q;
	assign status    = status_q;
	assign length    = length_q;
	assign fields    = fields_q;

endmodule
`default_nettype wire

// ----- hdl/modbus_rtu_meter_response_checker_unit.sv -----
// the frame-end beat passes the input register, then loads the result register;
// one byte per cycle unless a frame-end byte waits on a held output; CRC update and
// captures sit between the input register and the frame state / result register
// a result waiting at the output holds back only the next frame-end byte
// reset clears the frame state (count 0, crc 0xFFFF, captures 0) and loads
// expected address 1, expected function 3 and minimum length 71
`default_nettype none
module modbus_rtu_meter_response_checker_unit
	import mbrc_pkg::*;
#(
	parameter int unsigned MAX_FRAME = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [LEN_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [DATA_W-1:0]    data_byte,
	input  wire logic                 frame_end,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                frame_status,
	output logic [LEN_W-1:0]          frame_length,
	output logic [31:0]               flow_reading,
	output logic [31:0]               forward_total_raw,
	output logic [31:0]               reverse_total_raw,
	output logic [15:0]               pressure_reading,
	output logic [15:0]               meter_status,
	output logic [15:0]               temperature_raw,
	output logic [31:0]               serial_number,
	output logic [7:0]                device_id,
	output logic [15:0]               baud_setting
);

	logic [DATA_W-1:0] exp_addr_q;
	logic [DATA_W-1:0] exp_func_q;
	logic [LEN_W-1:0]  min_len_q;

	logic              valid_s1;
	logic [DATA_W-1:0] byte_s1;
	logic              last_s1;
	logic              advance;
	logic              out_free;
	frame_snap_t       snap;
	meter_fields_t     fields;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_addr_q <= EXP_ADDR_RST;
			exp_func_q <= EXP_FUNC_RST;
			min_len_q  <= MIN_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXP_ADDR: exp_addr_q <= cfg_data[DATA_W-1:0];
				REG_EXP_FUNC: exp_func_q <= cfg_data[DATA_W-1:0];
				REG_MIN_LEN:  min_len_q  <= cfg_data;
				default:      ;
			endcase
		end
	end

	// only a frame-end beat needs room in the result register
	assign out_free = !out_valid || out_ready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= frame_end;
		end
	end

	mbrc_frame_acc #(
		.MAX_FRAME(MAX_FRAME)
	) u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat_en   (advance),
		.data_byte (byte_s1),
		.frame_end (last_s1),
		.snap      (snap)
	);

	mbrc_result_reg u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && last_s1),
		.snap      (snap),
		.exp_addr  (exp_addr_q),
		.exp_func  (exp_func_q),
		.min_len   (min_len_q),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.status    (frame_status),
		.length    (frame_length),
		.fields    (fields)
	);

	assign flow_reading      = fields.flow;
	assign forward_total_raw = fields.forward_total;
	assign reverse_total_raw = fields.reverse_total;
	assign pressure_reading  = fields.pressure;
	assign meter_status      = fields.meter_status;
	assign temperature_raw   = fields.temperature;
	assign serial_number     = fields.serial_number;
	assign device_id         = fields.device_id;
	assign baud_setting      = fields.baud_setting;

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
	import mbrc_pkg::*;

	localparam int FRAME_LIMIT  = 256;
	localparam int RANDOM_ITEMS = 400;
	localparam int PHASE_ITEMS  = 100;
	localparam int HOLD_CYCLES  = 300;

	typedef struct packed {
		logic [1:0]       status;
		logic [LEN_W-1:0] length;
		meter_fields_t    fields;
	} meter_reply_t;

	typedef enum {
		KIND_GOOD,
		KIND_BAD_CRC,
		KIND_BAD_ADDR,
		KIND_BAD_FUNC,
		KIND_NOISE,
		KIND_CUT
	} frame_kind_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [LEN_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [DATA_W-1:0]    data_byte = '0;
	logic                 frame_end = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [1:0]           frame_status;
	logic [LEN_W-1:0]     frame_length;
	logic [31:0]          flow_reading;
	logic [31:0]          forward_total_raw;
	logic [31:0]          reverse_total_raw;
	logic [15:0]          pressure_reading;
	logic [15:0]          meter_status;
	logic [15:0]          temperature_raw;
	logic [31:0]          serial_number;
	logic [7:0]           device_id;
	logic [15:0]          baud_setting;

	modbus_rtu_meter_response_checker_unit #(
		.MAX_FRAME(FRAME_LIMIT)
	) i_dut (.*);

	// predictor copy of the registers
	logic [7:0]       match_addr = EXP_ADDR_RST;
	logic [7:0]       match_func = EXP_FUNC_RST;
	logic [LEN_W-1:0] least_len  = MIN_LEN_RST;

	// predictor copy of the frame in progress
	logic [LEN_W-1:0] fr_len       = '0;
	logic [15:0]      fr_crc       = 16'hFFFF;
	logic [7:0]       fr_addr_byte = '0;
	logic [7:0]       fr_func_byte = '0;
	meter_fields_t    fr_fields    = '0;

	meter_reply_t pending_replies[$];
	logic [7:0]   frame_bytes[$];

	int  mismatches = 0;
	int  counted_bytes = 0;
	int  frames_sent = 0;
	int  settings_applied = 0;
	int  status_tally[3] = '{0, 0, 0};
	bit  steady_flow = 1'b0;
	bit  hold_request = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [15:0] modbus_crc_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		repeat (8) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
		return r;
	endfunction

	// low word first, each word big-endian
	function automatic logic [31:0] put_swapped(input logic [31:0] w, input int off,
			input logic [7:0] b);
		case (off)
			0: w[15:8] = b;
			1: w[7:0] = b;
			2: w[31:24] = b;
			3: w[23:16] = b;
			default: ;
		endcase
		return w;
	endfunction

	task automatic predict_frame_byte(input logic [7:0] b, input logic last);
		meter_reply_t r;
		int p;
		if (fr_len < FRAME_LIMIT) begin
			p = int'(fr_len);
			fr_crc = modbus_crc_step(fr_crc, b);
			if (p == POS_ADDR) fr_addr_byte = b;
			if (p == POS_FUNC) fr_func_byte = b;
			fr_fields.flow = put_swapped(fr_fields.flow, p - int'(POS_FLOW), b);
			fr_fields.forward_total = put_swapped(fr_fields.forward_total,
				p - int'(POS_FORWARD), b);
			fr_fields.reverse_total = put_swapped(fr_fields.reverse_total,
				p - int'(POS_REVERSE), b);
			if (p == POS_PRESSURE) fr_fields.pressure[15:8] = b;
			if (p == POS_PRESSURE + 1) fr_fields.pressure[7:0] = b;
			if (p == POS_MSTATUS) fr_fields.meter_status[15:8] = b;
			if (p == POS_MSTATUS + 1) fr_fields.meter_status[7:0] = b;
			if (p == POS_TEMP) fr_fields.temperature[15:8] = b;
			if (p == POS_TEMP + 1) fr_fields.temperature[7:0] = b;
			if (p >= POS_SERIAL && p <= POS_SERIAL + 3)
				fr_fields.serial_number[8 * (int'(POS_SERIAL) + 3 - p) +: 8] = b;
			if (p == POS_ID) fr_fields.device_id = b;
			if (p == POS_BAUD) fr_fields.baud_setting[15:8] = b;
			if (p == POS_BAUD + 1) fr_fields.baud_setting[7:0] = b;
			fr_len++;
			counted_bytes++;
		end
		if (last) begin
			r = '0;
			r.length = fr_len;
			// too short wins over any check failure
			if (fr_len < least_len) begin
				r.status = STATUS_SHORT;
			end else if (fr_crc != 16'h0000 || fr_addr_byte != match_addr ||
					fr_func_byte != match_func) begin
				r.status = STATUS_FAIL;
			end else begin
				r.status = STATUS_OK;
				r.fields = fr_fields;
			end
			pending_replies.push_back(r);
			frames_sent++;
			fr_len = '0;
			fr_crc = 16'hFFFF;
			fr_addr_byte = '0;
			fr_func_byte = '0;
			fr_fields = '0;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		while (!steady_flow && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		frame_end <= last;
		do @(posedge clk); while (in_ready !== 1'b1);
		predict_frame_byte(b, last);
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	// fill < 0 gives a random body; bytes past the frame limit go after the crc
	task automatic make_good_frame(input logic [7:0] addr, input logic [7:0] func,
			input int total_len, input int fill);
		int kept;
		logic [15:0] c;
		kept = total_len > FRAME_LIMIT ? FRAME_LIMIT : total_len;
		frame_bytes.delete();
		frame_bytes.push_back(addr);
		frame_bytes.push_back(func);
		repeat (kept - 4) frame_bytes.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
		c = 16'hFFFF;
		foreach (frame_bytes[i]) c = modbus_crc_step(c, frame_bytes[i]);
		frame_bytes.push_back(c[7:0]);
		frame_bytes.push_back(c[15:8]);
		repeat (total_len - kept) frame_bytes.push_back(8'($urandom));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_replies.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_EXP_ADDR: match_addr = val[7:0];
			REG_EXP_FUNC: match_func = val[7:0];
			REG_MIN_LEN:  least_len = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [7:0] addr, input logic [7:0] func,
			input logic [LEN_W-1:0] min_len);
		wait_idle();
		write_reg(REG_EXP_ADDR, {1'b0, addr});
		write_reg(REG_EXP_FUNC, {1'b0, func});
		write_reg(REG_MIN_LEN, min_len);
		settings_applied++;
	endtask

	function automatic int pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 45) return $urandom_range(20, 4);
		if (r < 60) return $urandom_range(59, 21);
		if (r < 97) return $urandom_range(90, 60);
		return $urandom_range(264, 240);
	endfunction

	task automatic send_random_frame();
		frame_kind_t kind;
		int r;
		int pos;
		r = $urandom_range(99);
		if (r < 55) kind = KIND_GOOD;
		else if (r < 65) kind = KIND_BAD_CRC;
		else if (r < 72) kind = KIND_BAD_ADDR;
		else if (r < 79) kind = KIND_BAD_FUNC;
		else if (r < 90) kind = KIND_NOISE;
		else kind = KIND_CUT;
		case (kind)
			KIND_NOISE: begin
				frame_bytes.delete();
				repeat ($urandom_range(12, 1)) frame_bytes.push_back(8'($urandom));
			end
			KIND_BAD_ADDR: make_good_frame(match_addr ^ 8'($urandom_range(255, 1)), match_func,
				pick_length(), -1);
			KIND_BAD_FUNC: make_good_frame(match_addr, match_func ^ 8'($urandom_range(255, 1)),
				pick_length(), -1);
			default: make_good_frame(match_addr, match_func, pick_length(), -1);
		endcase
		if (kind == KIND_BAD_CRC) begin
			pos = $urandom_range(frame_bytes.size() - 1);
			frame_bytes[pos] ^= 8'(1 << $urandom_range(7));
		end
		if (kind == KIND_CUT)
			repeat ($urandom_range(frame_bytes.size() - 1, 1)) void'(frame_bytes.pop_back());
		send_frame();
	endtask

	task automatic test_reset_config();
		make_good_frame(EXP_ADDR_RST, EXP_FUNC_RST, 80, -1);
		send_frame();
		make_good_frame(EXP_ADDR_RST, EXP_FUNC_RST, 80, 8'hFF);
		send_frame();
		// one at the minimum length and one just below it
		make_good_frame(EXP_ADDR_RST, EXP_FUNC_RST, 71, -1);
		send_frame();
		make_good_frame(EXP_ADDR_RST, EXP_FUNC_RST, 70, -1);
		send_frame();
	endtask

	task automatic test_check_failures();
		set_config(8'd0, 8'd255, 9'd0);
		make_good_frame(8'd0, 8'd255, 10, 8'h00);
		send_frame();
		make_good_frame(8'd0, 8'd255, 80, 8'hFF);
		send_frame();
		make_good_frame(8'd0, 8'd255, 24, -1);
		frame_bytes[$] ^= 8'h80;
		send_frame();
		make_good_frame(8'd1, 8'd255, 24, -1);
		send_frame();
		make_good_frame(8'd0, 8'd254, 24, -1);
		send_frame();
		// frames too short to hold a crc, the first also without a function code
		frame_bytes = '{8'h00};
		send_frame();
		frame_bytes = '{8'h00, 8'hFF};
		send_frame();
		set_config(8'd255, 8'd0, 9'd100);
		make_good_frame(8'd255, 8'd0, 80, -1);
		frame_bytes[0] ^= 8'h01;
		send_frame();
		make_good_frame(8'd255, 8'd0, 100, -1);
		send_frame();
		set_config(8'd247, 8'd3, 9'd1);
		make_good_frame(8'd247, 8'd3, 4, -1);
		send_frame();
	endtask

	task automatic test_length_limits();
		set_config(8'd1, 8'd3, 9'd256);
		make_good_frame(8'd1, 8'd3, 256, -1);
		send_frame();
		// trailing bytes past the limit must not disturb crc or captures
		make_good_frame(8'd1, 8'd3, 262, -1);
		send_frame();
		make_good_frame(8'd1, 8'd3, 255, -1);
		send_frame();
		set_config(8'd1, 8'd3, 9'd257);
		make_good_frame(8'd1, 8'd3, 256, -1);
		send_frame();
		set_config(8'd1, 8'd3, 9'd511);
		make_good_frame(8'd1, 8'd3, 4, -1);
		send_frame();
	endtask

	task automatic test_output_hold();
		set_config(8'd1, 8'd3, 9'd0);
		steady_flow = 1'b1;
		hold_request = 1'b1;
		// short frames so finished results pile up behind the held output
		repeat (40) begin
			make_good_frame(8'd1, 8'd3, $urandom_range(6, 4), -1);
			send_frame();
		end
		steady_flow = 1'b0;
	endtask

	task automatic test_random_traffic();
		int byte_mark;
		int phase_mark;
		int phase;
		logic [7:0] a;
		logic [7:0] f;
		logic [LEN_W-1:0] m;
		byte_mark = counted_bytes;
		phase = 0;
		while (counted_bytes - byte_mark < RANDOM_ITEMS) begin
			case ($urandom_range(3))
				0: a = 8'd0;
				1: a = 8'd247;
				2: a = 8'd255;
				default: a = 8'($urandom);
			endcase
			case ($urandom_range(3))
				0: f = 8'd0;
				1: f = 8'd3;
				2: f = 8'd255;
				default: f = 8'($urandom);
			endcase
			case ($urandom_range(5))
				0: m = 9'd0;
				1: m = 9'd1;
				2: m = 9'd4;
				3: m = 9'd71;
				4: m = 9'($urandom_range(90));
				default: m = 9'd256;
			endcase
			set_config(a, f, m);
			steady_flow = (phase == 2);
			phase_mark = counted_bytes;
			while (counted_bytes - phase_mark < PHASE_ITEMS) send_random_frame();
			phase++;
		end
		steady_flow = 1'b0;
	endtask

	// output side: random stalls, with a long hold-off counted here on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady_flow || ($urandom_range(99) >= 28);
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		meter_reply_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
				if (pending_replies.size() == 0) begin
					$error("result beat with no frame outstanding: status %0d length %0d",
						frame_status, frame_length);
					mismatches++;
				end else begin
					want = pending_replies.pop_front();
					status_tally[want.status]++;
					check_field("frame_status", want.status, frame_status);
					check_field("frame_length", want.length, frame_length);
					check_field("flow_reading", want.fields.flow, flow_reading);
					check_field("forward_total_raw", want.fields.forward_total, forward_total_raw);
					check_field("reverse_total_raw", want.fields.reverse_total, reverse_total_raw);
					check_field("pressure_reading", want.fields.pressure, pressure_reading);
					check_field("meter_status", want.fields.meter_status, meter_status);
					check_field("temperature_raw", want.fields.temperature, temperature_raw);
					check_field("serial_number", want.fields.serial_number, serial_number);
					check_field("device_id", want.fields.device_id, device_id);
					check_field("baud_setting", want.fields.baud_setting, baud_setting);
				end
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_config();
		test_check_failures();
		test_length_limits();
		test_output_hold();
		test_random_traffic();
		wait_idle();
		repeat (8) @(negedge clk);
		$display("frames checked: %0d (%0d ok, %0d failed check, %0d too short), %0d bytes",
			frames_sent, status_tally[0], status_tally[1], status_tally[2], counted_bytes);
		$display("register settings applied: %0d, output held off once for %0d cycles",
			settings_applied, HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
